>>> hdl/mexp_pkg.sv
package mexp_pkg;

  localparam int DEF_WIDTH = 32;
  localparam int FIELD_W = 32;
  localparam int IN_TDATA_W = 3 * FIELD_W;
  localparam int OUT_TDATA_W = FIELD_W;

  typedef enum logic [1:0] {
    MUL_REDUCE = 2'd0,
    MUL_ACC    = 2'd1,
    MUL_SQR    = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_t mul_op;
    logic    shift_e;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic e_bit;
    logic e_zero;
    logic m_zero;
    logic out_free;
  } status_t;

endpackage

>>> hdl/mexp_datapath.sv
module mexp_datapath #(
  parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mexp_pkg::cmd_t               cmd,
  output mexp_pkg::status_t            status,
  input  logic [mexp_pkg::FIELD_W-1:0] in_base,
  input  logic [mexp_pkg::FIELD_W-1:0] in_exponent,
  input  logic [mexp_pkg::FIELD_W-1:0] in_modulus,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mexp_pkg::FIELD_W-1:0] out_result,
  output logic                         out_bad
);
  import mexp_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] b_reg, e_reg, m_reg, acc, pw;
  logic [WIDTH-1:0] mx, my, mr;
  logic [CW-1:0]    mcnt;
  logic             mbusy;
  mul_op_t          mop;

  logic [WIDTH-1:0] addend, r_next, in_m;
  logic [WIDTH+1:0] t;
  logic [WIDTH+2:0] d1, d2;

  assign in_m = WIDTH'(in_modulus);

  // one shift-add step: 2*mr + addend, reduced by up to two subtractions
  always_comb begin
    addend = my[WIDTH-1] ? mx : '0;
    t = {1'b0, mr, 1'b0} + {2'b00, addend};
    d1 = {1'b0, t} - {3'b000, m_reg};
    d2 = {1'b0, t} - {2'b00, m_reg, 1'b0};
    if (!d2[WIDTH+2]) begin
      r_next = d2[WIDTH-1:0];
    end else if (!d1[WIDTH+2]) begin
      r_next = d1[WIDTH-1:0];
    end else begin
      r_next = t[WIDTH-1:0];
    end
  end

  always_comb begin
    status.mul_done = mbusy && (mcnt == CW'(1));
    status.e_bit = e_reg[0];
    status.e_zero = (e_reg == '0);
    status.m_zero = (m_reg == '0);
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        b_reg <= WIDTH'(in_base);
        e_reg <= WIDTH'(in_exponent);
        m_reg <= in_m;
        acc <= (in_m == WIDTH'(1) && WIDTH'(in_exponent) != '0) ? '0 : WIDTH'(1);
      end
      if (cmd.shift_e) begin
        e_reg <= e_reg >> 1;
      end
      if (mbusy && mcnt == CW'(1)) begin
        case (mop)
          MUL_ACC: acc <= r_next;
          default: pw <= r_next;
        endcase
      end
      if (cmd.mul_start) begin
        mop <= cmd.mul_op;
        mr <= '0;
        mcnt <= CW'(WIDTH);
        mbusy <= 1'b1;
        case (cmd.mul_op)
          MUL_REDUCE: begin
            mx <= WIDTH'(1);
            my <= b_reg;
          end
          MUL_ACC: begin
            mx <= acc;
            my <= pw;
          end
          default: begin
            mx <= pw;
            my <= pw;
          end
        endcase
      end else if (mbusy) begin
        mr <= r_next;
        my <= my << 1;
        mcnt <= mcnt - CW'(1);
        if (mcnt == CW'(1)) begin
          mbusy <= 1'b0;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        out_result <= (m_reg == '0) ? '0 : FIELD_W'(acc);
        out_bad <= (m_reg == '0);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/mexp_ctrl.sv
module mexp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mexp_pkg::status_t status,
  output mexp_pkg::cmd_t    cmd
);
  import mexp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_REDUCE = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_MULACC = 7'b0010000,
    S_SQUARE = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_op = MUL_REDUCE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (status.m_zero || status.e_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op = MUL_REDUCE;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.mul_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.e_zero) begin
          state_next = S_FINISH;
        end else if (status.e_bit) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op = MUL_ACC;
          state_next = S_MULACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op = MUL_SQR;
          state_next = S_SQUARE;
        end
      end
      S_MULACC: begin
        if (status.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op = MUL_SQR;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        if (status.mul_done) begin
          cmd.shift_e = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/modular_exponentiation_core.sv
// Throughput: one item at a time; the next input is accepted once the sequencer is back
//   in idle, which it enters as the result is registered. Each modular multiply runs on
//   the single shift-add unit. Zero exponent or modulus: the sequencer skips the multiplies
//   and goes straight to its finish state.
//   A result held by the receiver stalls the core before it registers the next one.
// Reset: synchronous, active high; clears the sequencer, the multiplier busy flag and
//   the output valid flag.
module modular_exponentiation_core #(
  parameter int WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // base [31:0], exponent [63:32], modulus [95:64]
  input  logic [mexp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // power_result [31:0]
  output logic [mexp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // bad_modulus [0]
  output logic                             m_axis_tuser
);
  import mexp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_base     (s_axis_tdata[FIELD_W-1:0]),
    .in_exponent (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .in_modulus  (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (m_axis_tdata),
    .out_bad     (m_axis_tuser)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

  import mexp_pkg::*;

  localparam int HOLD_CYCLES = 3000;
  localparam int STALL_LIMIT = 20000;
  localparam int QUIET_TAIL = 40;
  localparam int RANDOM_ITEMS = 260;

  typedef struct {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
  } pow_request_t;

  typedef struct {
    logic [FIELD_W-1:0] power;
    logic               bad_modulus;
  } pow_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [IN_TDATA_W-1:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic m_user;

  pow_request_t requests_to_send[$];
  pow_answer_t  answers_due[$];

  int total_items = 0;
  int sent_items = 0;
  int got_items = 0;
  int errors = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int quiet_cycles = 0;

  modular_exponentiation_core DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic pow_answer_t modpow(pow_request_t req);
    pow_answer_t ans;
    longint unsigned m;
    longint unsigned run;
    longint unsigned acc;
    m = 64'(req.modulus);
    ans.bad_modulus = 1'b0;
    if (req.modulus == '0) begin
      ans.power = '0;
      ans.bad_modulus = 1'b1;
    end else if (req.exponent == '0) begin
      ans.power = FIELD_W'(1);
    end else begin
      run = 64'(req.base) % m;
      acc = 64'(1) % m;
      for (int i = 0; i < FIELD_W; i++) begin
        if (req.exponent[i]) acc = (acc * run) % m;
        run = (run * run) % m;
      end
      ans.power = acc[FIELD_W-1:0];
    end
    return ans;
  endfunction

  task automatic add_item(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e,
                          input logic [FIELD_W-1:0] m);
    pow_request_t req;
    req.base = b;
    req.exponent = e;
    req.modulus = m;
    requests_to_send.push_back(req);
  endtask

  // driver
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      offer = s_valid;
      if (s_valid && s_ready) begin
        answers_due.push_back(modpow(requests_to_send[0]));
        void'(requests_to_send.pop_front());
        sent_items++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (requests_to_send.size() > 0) begin
          if (sent_items < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 11);
          end else begin
            s_data <= {requests_to_send[0].modulus, requests_to_send[0].exponent,
                       requests_to_send[0].base};
            offer = 1'b1;
          end
        end
      end
      s_valid <= offer;
    end
  end

  // monitor
  always @(posedge clk) begin
    pow_answer_t want;
    bit ready_next;
    if (rst) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected item: power_result %h bad_modulus %b", m_data, m_user);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (m_data !== want.power) begin
            $error("power_result: expected %h, got %h", want.power, m_data);
            errors++;
          end
          if (m_user !== want.bad_modulus) begin
            $error("bad_modulus: expected %b, got %b", want.bad_modulus, m_user);
            errors++;
          end
        end
        got_items++;
      end
      ready_next = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!held_once && got_items == 30) begin
        // hold off long enough for the core to back up its input
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        ready_next = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        ready_next = 1'b0;
      end else if (got_items < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 11);
        ready_next = 1'b0;
      end
      m_ready <= ready_next;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("modular_exponentiation_core: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] e;
    logic [FIELD_W-1:0] m;
    int pick;

    add_item(32'd5, 32'd3, 32'd0);
    add_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
    add_item(32'd0, 32'd0, 32'd0);
    add_item(32'd7, 32'd0, 32'd1);
    add_item(32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF);
    add_item(32'd0, 32'd0, 32'd13);
    add_item(32'd9, 32'd5, 32'd1);
    add_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
    add_item(32'hFFFFFFFF, 32'd1, 32'd1000);
    add_item(32'd1000, 32'd1, 32'd1000);
    add_item(32'd0, 32'hFFFFFFFF, 32'd97);
    add_item(32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_item(32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_item(32'h12345678, 32'h80000000, 32'hFFFFFFFB);
    add_item(32'd2, 32'hFFFFFFFA, 32'hFFFFFFFB);
    add_item(32'd3, 32'd2, 32'd2);
    add_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000);
    add_item(32'hDEADBEEF, 32'h00010001, 32'hC0000001);
    add_item(32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAB);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) e = $urandom_range(0, 255);
      else if (pick < 6) e = $urandom_range(0, 65535);
      else e = $urandom;
      pick = $urandom_range(0, 19);
      if (pick == 0) m = '0;
      else if (pick == 1) m = 32'd1;
      else if (pick < 5) m = $urandom_range(2, 1000);
      else if (pick < 10) m = $urandom | 32'h80000000;
      else m = $urandom;
      pick = $urandom_range(0, 9);
      if (pick == 0) b = '0;
      else if (pick == 1) b = 32'hFFFFFFFF;
      else if (pick < 4) b = $urandom_range(0, 1000);
      else b = $urandom;
      add_item(b, e, m);
    end
    total_items = requests_to_send.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (requests_to_send.size() != 0 || answers_due.size() != 0) @(posedge clk);
    repeat (QUIET_TAIL) @(posedge clk);

    if (errors == 0) begin
      $display("modular_exponentiation_core: match");
    end else begin
      $display("modular_exponentiation_core: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/mexp_pkg.sv
hdl/mexp_datapath.sv
hdl/mexp_ctrl.sv
hdl/modular_exponentiation_core.sv
test/tb.sv
